// ===== design/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned MaxResult = 3;

  typedef logic [7:0]         byte_t;
  typedef logic [CpWidth-1:0] cp_t;
  typedef logic [1:0]         cnt_t;

  localparam cp_t BadCode = cp_t'(8'h3F);

  // decoder state: bytes of the open sequence, lead included
  typedef struct packed {
    logic [2:0][7:0] held;
    cnt_t            needed;
    cnt_t            nheld;
  } dec_state_t;

  // results caused by one input byte
  typedef struct packed {
    logic [MaxResult-1:0][CpWidth-1:0] cp;
    cnt_t                              cnt;
  } dec_result_t;

endpackage

// ===== design/u8d_byte_if.sv =====
// ----------------------------------------------------------------------------
// u8d_byte_if
// Byte request channel: one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic           valid;
  logic           ready;
  u8d_pkg::byte_t data_byte;
  logic           text_end;

  modport source (output valid, output data_byte, output text_end, input ready);
  modport sink   (input valid, input data_byte, input text_end, output ready);
endinterface

// ===== design/u8d_cp_if.sv =====
// ----------------------------------------------------------------------------
// u8d_cp_if
// Code point request channel.
// ----------------------------------------------------------------------------
interface u8d_cp_if;
  logic         valid;
  logic         ready;
  u8d_pkg::cp_t code_point;
  logic         run_last;
  logic         final_of_text;

  modport source (output valid, output code_point, output run_last,
                  output final_of_text, input ready);
  modport sink   (input valid, input code_point, input run_last,
                  input final_of_text, output ready);
endinterface

// ===== design/u8d_decode.sv =====
// ----------------------------------------------------------------------------
// u8d_decode
// Next-state and result logic for one byte: sequence tracking, assembly and
// the end-of-text flush of an unfinished sequence.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  u8d_pkg::dec_state_t  st_i,
  input  u8d_pkg::byte_t       data_byte_i,
  input  logic                 text_end_i,
  output u8d_pkg::dec_state_t  st_o,
  output u8d_pkg::dec_result_t res_o
);
  import u8d_pkg::*;

  // 0 = invalid lead, else sequence length 1..4
  function automatic logic [2:0] lead_len(byte_t b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic cp_t assemble(logic [3:0][7:0] s, logic [2:0] len);
    cp_t cp;
    case (len)
      3'd2:    cp = cp_t'({s[0][4:0], s[1][5:0]});
      3'd3:    cp = cp_t'({s[0][3:0], s[1][5:0], s[2][5:0]});
      3'd4:    cp = cp_t'({s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]});
      default: cp = cp_t'(s[0]);
    endcase
    return cp;
  endfunction

  // a lone byte of a flushed tail
  function automatic cp_t single(byte_t b);
    return (lead_len(b) == 3'd1) ? cp_t'(b) : BadCode;
  endfunction

  logic [3:0][7:0] seq;
  logic [2:0]      len;
  logic [2:0]      total;

  always_comb begin
    seq   = {8'h00, st_i.held[2], st_i.held[1], st_i.held[0]};
    seq[st_i.nheld] = data_byte_i;
    len   = lead_len(data_byte_i);
    total = {1'b0, st_i.nheld} + 3'd1;
    st_o  = st_i;
    res_o = '0;

    if (st_i.nheld == '0) begin
      if (len == 3'd0) begin
        res_o.cp[0] = BadCode;
        res_o.cnt   = cnt_t'(1);
      end else if (len == 3'd1) begin
        res_o.cp[0] = cp_t'(data_byte_i);
        res_o.cnt   = cnt_t'(1);
      end else if (text_end_i) begin
        res_o.cp[0] = BadCode;
        res_o.cnt   = cnt_t'(1);
      end else begin
        st_o.held[0] = data_byte_i;
        st_o.nheld   = cnt_t'(1);
        st_o.needed  = cnt_t'(len - 3'd1);
      end
    end else if (total >= {1'b0, st_i.needed} + 3'd1) begin
      res_o.cp[0] = assemble(seq, total);
      res_o.cnt   = cnt_t'(1);
      st_o        = '0;
    end else if (text_end_i) begin
      // lead is bad, rest decoded again as a short text
      res_o.cp[0] = BadCode;
      if (st_i.nheld == cnt_t'(1)) begin
        res_o.cp[1] = single(seq[1]);
        res_o.cnt   = cnt_t'(2);
      end else if (lead_len(seq[1]) == 3'd2) begin
        res_o.cp[1] = assemble({16'h0000, seq[2], seq[1]}, 3'd2);
        res_o.cnt   = cnt_t'(2);
      end else begin
        res_o.cp[1] = single(seq[1]);
        res_o.cp[2] = single(seq[2]);
        res_o.cnt   = cnt_t'(3);
      end
      st_o = '0;
    end else begin
      st_o.held[st_i.nheld] = data_byte_i;
      st_o.nheld            = cnt_t'(total);
    end
  end

endmodule

// ===== design/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with end-of-text flush.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless held off and returns one code point per
// cycle while the output is ready, via the input then the result register.
// An ASCII byte, an invalid lead, a multi-byte lead that ends the text, or a
// byte that completes a sequence gives one result. A byte that ends the text
// inside an unfinished sequence gives two or three, drained one per cycle
// while the output is ready; input is held off until the last is taken.
// Lead bytes of multi-byte sequences give no result. Continuation bytes are
// not checked and overlong forms pass; an invalid lead gives 0x3F.
module utf8_stream_decoder (
  input logic clk_i,
  input logic rst_ni,
  u8d_byte_if.sink  in_i,
  u8d_cp_if.source  out_o
);
  import u8d_pkg::*;

  logic                              in_vld_q;
  byte_t                             in_byte_q;
  logic                              in_end_q;
  dec_state_t                        st_q, st_d;
  dec_result_t                       res;
  cnt_t                              grp_cnt_q;
  logic [MaxResult-1:0][CpWidth-1:0] grp_cp_q;
  logic                              grp_end_q;
  logic                              pop;
  logic                              grp_free;
  logic                              move;

  assign pop      = out_o.valid && out_o.ready;
  assign grp_free = (grp_cnt_q == '0) || (grp_cnt_q == cnt_t'(1) && out_o.ready);
  assign move     = in_vld_q && grp_free;
  assign in_i.ready = !in_vld_q || move;

  u8d_decode u_decode (
    .st_i        (st_q),
    .data_byte_i (in_byte_q),
    .text_end_i  (in_end_q),
    .st_o        (st_d),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_end_q  <= in_i.text_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      grp_cnt_q <= '0;
    end else if (move) begin
      st_q      <= st_d;
      grp_cnt_q <= res.cnt;
    end else if (pop) begin
      grp_cnt_q <= grp_cnt_q - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      grp_cp_q  <= res.cp;
      grp_end_q <= in_end_q;
    end else if (pop) begin
      grp_cp_q[0] <= grp_cp_q[1];
      grp_cp_q[1] <= grp_cp_q[2];
    end
  end

  assign out_o.valid         = (grp_cnt_q != '0);
  assign out_o.code_point    = grp_cp_q[0];
  assign out_o.run_last      = (grp_cnt_q == cnt_t'(1));
  assign out_o.final_of_text = (grp_cnt_q == cnt_t'(1)) && grp_end_q;

`ifndef SYNTHESIS
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && in_end_q |=> st_q.nheld == '0)
    else $error("sequence left open after end of text");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.nheld != '0 |-> st_q.nheld <= st_q.needed)
    else $error("held byte count beyond sequence length");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !move |=> in_vld_q && $stable(in_byte_q) && $stable(in_end_q))
    else $error("stalled input register changed");

  a_group_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_cnt_q > cnt_t'(1) |-> !move)
    else $error("new byte decoded while results pending");
`endif

endmodule
